@@ hw/rtl/cslt_pkg.sv @@
// cslt_pkg: shared types and codes of the circular slot mapping table
// transaction structs, operation and status codes, controller/datapath links
// depends on nothing
package cslt_pkg;

  // field widths of one transaction
  localparam int unsigned FUNC_W   = 2;
  localparam int unsigned ADDR_W   = 32;
  localparam int unsigned HANDLE_W = 32;
  localparam int unsigned SLOT_W   = 4;
  localparam int unsigned STATUS_W = 2;

  // operation codes
  typedef enum logic [FUNC_W-1:0] {
    FUNC_STORE   = 2'd0,
    FUNC_LOOKUP  = 2'd1,
    FUNC_RELEASE = 2'd2
  } func_e;

  // result status codes
  typedef enum logic [STATUS_W-1:0] {
    STATUS_OK   = 2'd0,
    STATUS_FULL = 2'd1,
    STATUS_MISS = 2'd2
  } status_e;

  // request transaction
  typedef struct packed {
    logic [FUNC_W-1:0]   func;
    logic [ADDR_W-1:0]   buffer_address;
    logic [HANDLE_W-1:0] buffer_handle;
    logic [SLOT_W-1:0]   release_slot;
  } req_t;

  // result transaction
  typedef struct packed {
    logic [STATUS_W-1:0] status;
    logic [SLOT_W-1:0]   found_slot;
    logic [HANDLE_W-1:0] found_handle;
  } res_t;

  // which result the datapath builds
  typedef enum logic [2:0] {
    RES_NONE   = 3'd0,
    RES_STORED = 3'd1,
    RES_FULL   = 3'd2,
    RES_HIT    = 3'd3,
    RES_MISS   = 3'd4
  } res_kind_e;

  // controller states
  typedef enum logic [1:0] {
    ST_IDLE   = 2'd0,
    ST_STORE  = 2'd1,
    ST_LOOKUP = 2'd2,
    ST_DRAIN  = 2'd3
  } state_e;

  // commands from controller to datapath
  typedef struct packed {
    logic      load;
    logic      step_fwd;
    logic      step_back;
    logic      issue;
    logic      write_slot;
    logic      free_slot;
    logic      emit;
    res_kind_e kind;
  } cmd_t;

  // status from datapath to controller
  typedef struct packed {
    logic [FUNC_W-1:0] func;
    logic              addr_zero;
    logic              free_here;
    logic              last;
    logic              hit;
  } stat_t;

endpackage

@@ hw/rtl/cslt_ctrl.sv @@
// cslt_ctrl: sequencing state machine of the slot table
// drives datapath commands from datapath status; uses cslt_pkg
module cslt_ctrl (
  input  logic            clk_i,
  input  logic            rst_ni,
  input  logic            start_i,
  input  cslt_pkg::stat_t stat_i,
  output cslt_pkg::cmd_t  cmd_o,
  output logic            busy_o
);
  import cslt_pkg::*;

  state_e state_q, state_d;

  // state register
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= ST_IDLE;
    end else begin
      state_q <= state_d;
    end
  end

  // next state
  always_comb begin
    state_d = state_q;
    unique case (state_q)
      ST_IDLE: begin
        if (start_i) begin
          unique case (stat_i.func)
            FUNC_STORE:  state_d = ST_STORE;
            FUNC_LOOKUP: state_d = stat_i.addr_zero ? ST_IDLE : ST_LOOKUP;
            default:     state_d = ST_IDLE;
          endcase
        end
      end
      ST_STORE: begin
        if (stat_i.free_here || stat_i.last) state_d = ST_IDLE;
      end
      ST_LOOKUP: begin
        priority if (stat_i.hit) state_d = ST_IDLE;
        else if (stat_i.last)    state_d = ST_DRAIN;
        else                     state_d = ST_LOOKUP;
      end
      ST_DRAIN: state_d = ST_IDLE;
      default:  state_d = ST_IDLE;
    endcase
  end

  // command outputs
  always_comb begin
    cmd_o      = '0;
    cmd_o.kind = RES_NONE;
    unique case (state_q)
      ST_IDLE: begin
        if (start_i) begin
          cmd_o.load = 1'b1;
          unique case (stat_i.func)
            FUNC_STORE: ;
            FUNC_LOOKUP: begin
              if (stat_i.addr_zero) begin
                cmd_o.emit = 1'b1;
                cmd_o.kind = RES_MISS;
              end
            end
            FUNC_RELEASE: begin
              cmd_o.free_slot = 1'b1;
              cmd_o.emit      = 1'b1;
            end
            default: cmd_o.emit = 1'b1;
          endcase
        end
      end
      ST_STORE: begin
        priority if (stat_i.free_here) begin
          cmd_o.write_slot = 1'b1;
          cmd_o.emit       = 1'b1;
          cmd_o.kind       = RES_STORED;
        end else if (stat_i.last) begin
          cmd_o.emit = 1'b1;
          cmd_o.kind = RES_FULL;
        end else begin
          cmd_o.step_fwd = 1'b1;
        end
      end
      ST_LOOKUP: begin
        priority if (stat_i.hit) begin
          cmd_o.emit = 1'b1;
          cmd_o.kind = RES_HIT;
        end else begin
          cmd_o.issue     = 1'b1;
          cmd_o.step_back = !stat_i.last;
        end
      end
      ST_DRAIN: begin
        cmd_o.emit = 1'b1;
        cmd_o.kind = stat_i.hit ? RES_HIT : RES_MISS;
      end
      default: ;
    endcase
  end

  assign busy_o = (state_q != ST_IDLE);

endmodule

@@ hw/rtl/cslt_dpath.sv @@
// cslt_dpath: slot storage, ring position, scan index and result register
// entry memory with registered read, used flags in flops; uses cslt_pkg
module cslt_dpath #(
  parameter int unsigned SLOTS = 16
) (
  input  logic            clk_i,
  input  logic            rst_ni,
  input  cslt_pkg::req_t  req_i,
  input  cslt_pkg::cmd_t  cmd_i,
  output cslt_pkg::stat_t stat_o,
  output logic            done_o,
  output cslt_pkg::res_t  res_o
);
  import cslt_pkg::*;

  localparam int unsigned IW = $clog2(SLOTS);
  localparam logic [IW-1:0] LAST_IDX = IW'(SLOTS - 1);

  typedef struct packed {
    logic [ADDR_W-1:0]   addr;
    logic [HANDLE_W-1:0] handle;
  } entry_t;

  entry_t              mem [SLOTS];
  entry_t              rd_entry_q;
  logic [IW-1:0]       rd_idx_q;
  logic                rd_vld_q;

  logic [ADDR_W-1:0]   addr_q, addr_d;
  logic [HANDLE_W-1:0] handle_q, handle_d;
  logic [IW-1:0]       idx_q, idx_d;
  logic [IW-1:0]       cnt_q, cnt_d;
  logic [IW-1:0]       ring_q, ring_d;
  logic [SLOTS-1:0]    used_q, used_d;
  logic                done_q, done_d;
  res_t                res_q, res_d;

  // operand capture and scan index
  always_comb begin
    addr_d   = addr_q;
    handle_d = handle_q;
    idx_d    = idx_q;
    cnt_d    = cnt_q;
    priority if (cmd_i.load) begin
      addr_d   = req_i.buffer_address;
      handle_d = req_i.buffer_handle;
      idx_d    = ring_q;
      cnt_d    = '0;
    end else if (cmd_i.step_fwd) begin
      idx_d = (idx_q == LAST_IDX) ? '0 : idx_q + IW'(1);
      cnt_d = cnt_q + IW'(1);
    end else if (cmd_i.step_back) begin
      idx_d = (idx_q == '0) ? LAST_IDX : idx_q - IW'(1);
      cnt_d = cnt_q + IW'(1);
    end else begin
      idx_d = idx_q;
    end
  end

  // used flags and ring position
  always_comb begin
    used_d = used_q;
    ring_d = ring_q;
    if (cmd_i.write_slot) begin
      used_d[idx_q] = (addr_q != '0);
      ring_d        = idx_q;
    end
    for (int unsigned i = 0; i < SLOTS; i++) begin
      if (cmd_i.free_slot && (32'(req_i.release_slot) == i)) used_d[i] = 1'b0;
    end
  end

  // result build
  always_comb begin
    res_d  = res_q;
    done_d = cmd_i.emit;
    if (cmd_i.emit) begin
      res_d.status       = STATUS_OK;
      res_d.found_slot   = '0;
      res_d.found_handle = '0;
      unique case (cmd_i.kind)
        RES_NONE:   ;
        RES_STORED: res_d.found_slot = SLOT_W'(idx_q);
        RES_FULL:   res_d.status = STATUS_FULL;
        RES_HIT: begin
          res_d.found_slot   = SLOT_W'(rd_idx_q);
          res_d.found_handle = rd_entry_q.handle;
        end
        RES_MISS:   res_d.status = STATUS_MISS;
        default:    ;
      endcase
    end
  end

  // control registers
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      idx_q    <= '0;
      cnt_q    <= '0;
      ring_q   <= '0;
      used_q   <= '0;
      done_q   <= 1'b0;
      rd_vld_q <= 1'b0;
    end else begin
      idx_q    <= idx_d;
      cnt_q    <= cnt_d;
      ring_q   <= ring_d;
      used_q   <= used_d;
      done_q   <= done_d;
      rd_vld_q <= cmd_i.issue;
    end
  end

  // payload registers
  always_ff @(posedge clk_i) begin
    addr_q   <= addr_d;
    handle_q <= handle_d;
    res_q    <= res_d;
  end

  // entry memory, one write and one registered read
  always_ff @(posedge clk_i) begin
    if (cmd_i.write_slot) begin
      mem[idx_q] <= '{addr: addr_q, handle: handle_q};
    end
    if (cmd_i.issue) begin
      rd_entry_q <= mem[idx_q];
      rd_idx_q   <= idx_q;
    end
  end

  // status to controller
  assign stat_o.func      = req_i.func;
  assign stat_o.addr_zero = (req_i.buffer_address == '0);
  assign stat_o.free_here = !used_q[idx_q];
  assign stat_o.last      = (cnt_q == LAST_IDX);
  assign stat_o.hit       = rd_vld_q && used_q[rd_idx_q] && (rd_entry_q.addr == addr_q);

  assign done_o = done_q;
  assign res_o  = res_q;

endmodule

@@ hw/rtl/circular_slot_mapping_table.sv @@
// circular_slot_mapping_table: top level of the address to handle slot ring
// joins cslt_ctrl and cslt_dpath; uses cslt_pkg
//
// A request is taken at a clock edge where start is high and busy is low; its
// result shows on res_o for exactly one cycle with done_o high, and cannot be
// held off, so the receiver must take it then. A release, an unused operation
// code, or a lookup of address zero finishes at once: the result comes in the
// next cycle and busy stays low, so a new request may follow right away. A
// store scans forward from the ring position and is busy until it finds the
// first free slot, or until it has visited every slot when the table is full.
// A lookup scans backward from the ring position and is busy until a slot
// matches, or on a miss through the last slot and the drain state. The scan
// visits one slot per cycle; a lookup reads each slot through the single
// registered read port of the entry memory. The result shows in the first
// cycle with busy low. Reset frees all slots at once; no clearing pass.
module circular_slot_mapping_table #(
  parameter int unsigned SLOTS = 16
) (
  input  logic           clk_i,
  input  logic           rst_ni,
  input  logic           start,
  output logic           busy,
  input  cslt_pkg::req_t req_i,
  output logic           done_o,
  output cslt_pkg::res_t res_o
);
  import cslt_pkg::*;

  cmd_t  cmd;
  stat_t stat;

  // sequencer
  cslt_ctrl u_ctrl (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .start_i(start),
    .stat_i (stat),
    .cmd_o  (cmd),
    .busy_o (busy)
  );

  // storage and result datapath
  cslt_dpath #(
    .SLOTS(SLOTS)
  ) u_dpath (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .req_i  (req_i),
    .cmd_i  (cmd),
    .stat_o (stat),
    .done_o (done_o),
    .res_o  (res_o)
  );

endmodule

@@ hw/rtl/cslt_checker.sv @@
// cslt_checker: port level checks of the slot table over time
// bound to circular_slot_mapping_table; uses cslt_pkg
module cslt_checker (
  input logic           clk_i,
  input logic           rst_ni,
  input logic           start,
  input logic           busy,
  input cslt_pkg::req_t req_i,
  input logic           done_o,
  input cslt_pkg::res_t res_o
);
  import cslt_pkg::*;

  // a release transaction completes in the next cycle without going busy
  a_release_quick: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (start && !busy && req_i.func == FUNC_RELEASE) |=> (done_o && !busy))
    else $error("release did not complete in one cycle");

  // a store always scans
  a_store_busy: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (start && !busy && req_i.func == FUNC_STORE) |=> (busy && !done_o))
    else $error("store did not enter its scan");

  // leaving busy always delivers a result
  a_fell_done: assert property (@(posedge clk_i) disable iff (!rst_ni)
    $fell(busy) |-> done_o)
    else $error("busy dropped without a result");

  // a result only follows an accepted request or busy work
  a_done_cause: assert property (@(posedge clk_i) disable iff (!rst_ni)
    done_o |-> ($past(busy) || $past(start && !busy)))
    else $error("result without a transaction");

  // full and miss results carry no slot and no handle
  a_fail_zero: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (done_o && (res_o.status == STATUS_FULL || res_o.status == STATUS_MISS))
      |-> (res_o.found_slot == '0 && res_o.found_handle == '0))
    else $error("failed result carries data");

endmodule

bind circular_slot_mapping_table cslt_checker u_cslt_checker (.*);
